>>> src/ldc_pkg.sv
package ldc_pkg;

    // field widths fixed by the item format
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 64;
    localparam int CFG_IDX_W = 2;

    // default vector length
    localparam int DEF_MAX_FEATURES = 1024;

    // item kinds carried on tuser
    localparam logic ACT_WEIGHT  = 1'b0;
    localparam logic ACT_FEATURE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_PROJ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_PROJ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 2'd2;

    // reset value of the boundary position, 0.5 in Q16.16
    localparam logic [VAL_W-1:0] BOUNDARY_RST = 32'h0000_8000;

    // cycles from a config write until the threshold is settled
    localparam int THR_LAT = 5;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic                    pos_gt;
        logic signed [SUM_W-1:0] k;
    } thr_t;

endpackage

>>> src/ldc_weight_mem.sv
module ldc_weight_mem
    import ldc_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_FEATURES,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [VAL_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [VAL_W-1:0]  rdata_reg
);

    logic [VAL_W-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

>>> src/ldc_threshold.sv
module ldc_threshold
    import ldc_pkg::*;
(
    input  logic                    clk,
    input  logic signed [SUM_W-1:0] pos_proj,
    input  logic signed [SUM_W-1:0] neg_proj,
    input  logic signed [VAL_W-1:0] boundary,
    output thr_t                    thr
);

    localparam int F_W  = VAL_W + 1;
    localparam int HW   = SUM_W / 2;
    localparam int P_W  = HW + F_W;
    localparam int M_W  = SUM_W + F_W;
    localparam int Q_W  = M_W - 16;
    localparam int SQ_W = Q_W + 1;
    localparam int T_W  = SQ_W + 1;

    // stage a: pick branch, difference and fraction magnitude
    logic                    a_pgt_reg, a_neg_reg;
    logic signed [SUM_W-1:0] a_base_reg;
    logic [SUM_W-1:0]        a_diff_reg;
    logic [F_W-1:0]          a_fm_reg;
    logic                    a_pgt_next;
    logic signed [F_W-1:0]   a_f;

    // stage b: partial products
    logic                    b_pgt_reg, b_neg_reg;
    logic signed [SUM_W-1:0] b_base_reg;
    logic [P_W-1:0]          b_p0_reg, b_p1_reg;

    // stage c: full product
    logic                    c_pgt_reg, c_neg_reg;
    logic signed [SUM_W-1:0] c_base_reg;
    logic [M_W-1:0]          c_m_reg;

    // stage d: scaled and signed offset
    logic                    d_pgt_reg;
    logic signed [SUM_W-1:0] d_base_reg;
    logic signed [SQ_W-1:0]  d_sq_reg;
    logic                    c_rnd;
    logic [SQ_W-1:0]         c_fl;

    // stage e: add base and saturate
    logic                    e_pgt_reg;
    logic signed [SUM_W-1:0] e_k_reg;
    logic signed [T_W-1:0]   d_t;
    logic signed [SUM_W-1:0] d_k;

    assign a_pgt_next = pos_proj > neg_proj;
    assign a_f = a_pgt_next ? F_W'(boundary)
                            : F_W'(65536) - F_W'(boundary);

    always_ff @(posedge clk)
    begin
        a_pgt_reg  <= a_pgt_next;
        a_base_reg <= a_pgt_next ? neg_proj : pos_proj;
        a_diff_reg <= a_pgt_next ? SUM_W'(pos_proj - neg_proj)
                                 : SUM_W'(neg_proj - pos_proj);
        a_neg_reg  <= a_f[F_W-1];
        a_fm_reg   <= a_f[F_W-1] ? F_W'(-a_f) : F_W'(a_f);
    end

    // two 32 by 33 multiplies on the halves of the difference
    always_ff @(posedge clk)
    begin
        b_pgt_reg  <= a_pgt_reg;
        b_neg_reg  <= a_neg_reg;
        b_base_reg <= a_base_reg;
        b_p0_reg   <= P_W'(a_diff_reg[HW-1:0]) * P_W'(a_fm_reg);
        b_p1_reg   <= P_W'(a_diff_reg[SUM_W-1:HW]) * P_W'(a_fm_reg);
    end

    always_ff @(posedge clk)
    begin
        c_pgt_reg  <= b_pgt_reg;
        c_neg_reg  <= b_neg_reg;
        c_base_reg <= b_base_reg;
        c_m_reg    <= M_W'(b_p0_reg) + {b_p1_reg, {HW{1'b0}}};
    end

    // floor for a positive fraction; for a negative one -ceil = ~floor + !rounded
    assign c_rnd = c_m_reg[15:0] != 16'd0;
    assign c_fl  = {1'b0, c_m_reg[M_W-1:16]};

    always_ff @(posedge clk)
    begin
        d_pgt_reg  <= c_pgt_reg;
        d_base_reg <= c_base_reg;
        d_sq_reg   <= c_neg_reg ? $signed(~c_fl + SQ_W'(!c_rnd)) : $signed(c_fl);
    end

    assign d_t = T_W'(d_sq_reg) + T_W'(d_base_reg);

    always_comb
    begin
        if (d_t[T_W-1:SUM_W-1] == {(T_W-SUM_W+1){1'b0}} ||
            d_t[T_W-1:SUM_W-1] == {(T_W-SUM_W+1){1'b1}})
        begin
            d_k = d_t[SUM_W-1:0];
        end
        else if (d_t[T_W-1])
        begin
            d_k = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            d_k = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        e_pgt_reg <= d_pgt_reg;
        e_k_reg   <= d_k;
    end

    assign thr.pos_gt = e_pgt_reg;
    assign thr.k      = e_k_reg;

endmodule

>>> src/ldc_mac_pipe.sv
module ldc_mac_pipe
    import ldc_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  item_t                   item,
    input  logic                    hold,
    input  thr_t                    thr,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_positive,
    output logic signed [SUM_W-1:0] out_proj
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int EXT_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    // input decode
    logic [EXT_W-1:0]  idx_ext;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              in_acc;
    logic [VAL_W-1:0]  wt_rd;

    // stage 1: weight read
    logic                    v1_reg, act1_reg, inr1_reg, last1_reg;
    logic signed [VAL_W-1:0] val1_reg;

    // stage 2: product
    logic                    v2_reg, act2_reg, last2_reg;
    logic signed [SUM_W-1:0] prod2_reg;
    logic signed [VAL_W-1:0] wt1;
    logic signed [SUM_W-1:0] prod_next;

    // stage 3: accumulated sum
    logic                    v3_reg, res3_reg;
    logic signed [SUM_W-1:0] sum3_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_raw, acc_sat;

    // output register
    logic                    ov_reg, opos_reg;
    logic signed [SUM_W-1:0] oproj_reg;
    logic                    cmp_pos;

    // stage advance
    logic out_load, free3, free2, free1;

    assign idx_ext  = EXT_W'(item.index);
    assign in_range = idx_ext < EXT_W'(MAX_FEATURES);
    assign addr     = idx_ext[ADDR_W-1:0];

    assign out_load = !ov_reg || out_ready;
    assign free3    = !v3_reg || !res3_reg || out_load;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1 && !hold;
    assign in_acc   = in_valid && in_ready;

    ldc_weight_mem #(
        .DEPTH (MAX_FEATURES)
    ) u_mem (
        .clk       (clk),
        .we        (in_acc && item.action == ACT_WEIGHT && in_range),
        .waddr     (addr),
        .wdata     (item.value),
        .re        (in_acc),
        .raddr     (addr),
        .rdata_reg (wt_rd)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_acc;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (out_load)
            begin
                ov_reg <= v3_reg && res3_reg;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            act1_reg  <= item.action;
            inr1_reg  <= in_range;
            val1_reg  <= item.value;
            last1_reg <= item.last;
        end
    end

    // multiply feature by weight, zero weight past the vector end
    assign wt1       = $signed(wt_rd);
    assign prod_next = inr1_reg ? SUM_W'(wt1 * val1_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            act2_reg  <= act1_reg;
            last2_reg <= last1_reg;
            prod2_reg <= prod_next;
        end
    end

    // saturating accumulate
    assign acc_raw = acc_reg + prod2_reg;

    always_comb
    begin
        if (acc_reg[SUM_W-1] == prod2_reg[SUM_W-1] &&
            acc_raw[SUM_W-1] != prod2_reg[SUM_W-1])
        begin
            acc_sat = prod2_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (free3 && v2_reg && act2_reg == ACT_FEATURE)
        begin
            acc_reg <= last2_reg ? '0 : acc_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            res3_reg <= act2_reg == ACT_FEATURE && last2_reg;
            sum3_reg <= acc_sat;
        end
    end

    // compare with the threshold on the side of the larger projection
    assign cmp_pos = thr.pos_gt ? (sum3_reg > thr.k) : (sum3_reg < thr.k);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            opos_reg  <= cmp_pos;
            oproj_reg <= sum3_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign out_positive = opos_reg;
    assign out_proj     = oproj_reg;

endmodule

>>> src/linear_discriminant_classifier_top.sv
// Linear discriminant classifier, Q16.16 values and Q32.32 sums.
// Slave stream: tuser is the item kind (0 loads a weight, 1 feeds a feature
// element), tdata carries index and value, tlast closes a feature vector.
// Each feature element is multiplied by the stored weight at its index and
// added into a saturating accumulator. On the last element one result beat
// leaves the master stream with the class bit and the projection.
// Config channel: cfg_index selects positive projection (0), negative
// projection (1) or boundary position (2); write only while idle.
// Throughput: one beat per cycle when not held off by a config write or a
// stalled result, set by the single multiply-accumulate loop. m_tvalid
// rises once the last feature beat has passed the weight read, product,
// sum and output registers. After reset and after each config write
// s_tready stays low while the 5-stage threshold pipeline settles.
// Reset clears the accumulator and valid bits; weights are undefined until
// loaded. A stalled receiver holds the result in the output register; other
// beats keep flowing until a second result needs that register.
module linear_discriminant_classifier_top
    import ldc_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // element_index[9:0], element_value[41:10]
    input  logic                 s_tuser,   // action
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // is_positive[0], projection_value[64:1]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_data
);

    localparam int BUSY_W = $clog2(THR_LAT + 1);

    logic signed [SUM_W-1:0] pos_proj_reg, neg_proj_reg;
    logic signed [VAL_W-1:0] boundary_reg;
    logic [BUSY_W-1:0]       busy_reg;
    logic                    cfg_acc;
    item_t                   item;
    thr_t                    thr;
    logic                    out_positive;
    logic signed [SUM_W-1:0] out_proj;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_proj_reg <= '0;
            neg_proj_reg <= '0;
            boundary_reg <= BOUNDARY_RST;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                CFG_POS_PROJ: pos_proj_reg <= cfg_data;
                CFG_NEG_PROJ: neg_proj_reg <= cfg_data;
                CFG_BOUNDARY: boundary_reg <= cfg_data[VAL_W-1:0];
                default:      ;
            endcase
        end
    end

    // hold off input while the threshold settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= BUSY_W'(THR_LAT);
        end
        else if (cfg_acc)
        begin
            busy_reg <= BUSY_W'(THR_LAT);
        end
        else if (busy_reg != '0)
        begin
            busy_reg <= busy_reg - BUSY_W'(1);
        end
    end

    ldc_threshold u_thr (
        .clk      (clk),
        .pos_proj (pos_proj_reg),
        .neg_proj (neg_proj_reg),
        .boundary (boundary_reg),
        .thr      (thr)
    );

    // unpack the input beat
    assign item.action = s_tuser;
    assign item.index  = s_tdata[IDX_W-1:0];
    assign item.value  = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign item.last   = s_tlast;

    ldc_mac_pipe #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .item         (item),
        .hold         (busy_reg != '0),
        .thr          (thr),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_positive (out_positive),
        .out_proj     (out_proj)
    );

    assign m_tdata = {7'd0, out_proj, out_positive};

endmodule
